[sv/cle_pkg.sv]
package cle_pkg;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 8;
  localparam int ST_W   = 2;
  localparam int LEN_W  = 8;

  typedef enum logic [OP_W-1:0] {
    OP_CHAR = 2'd0,
    OP_END  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum logic [ST_W-1:0] {
    ST_PROGRESS = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_EOF      = 2'd2,
    ST_READ     = 2'd3
  } status_e;

  localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
  localparam logic [CHAR_W-1:0] CH_DEL = 8'd127;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

  typedef struct packed {
    logic             valid;
    status_e          status;
    logic [LEN_W-1:0] length;
    logic             hit;
  } rsp_t;

endpackage

[sv/cle_if.sv]
interface cle_req_if;
  logic                       valid;
  logic                       ready;
  logic [cle_pkg::OP_W-1:0]   operation;
  logic [cle_pkg::CHAR_W-1:0] char_code;
  logic [cle_pkg::IDX_W-1:0]  read_index;

  modport source (output valid, output operation, output char_code, output read_index,
                  input ready);
  modport sink (input valid, input operation, input char_code, input read_index,
                output ready);
endinterface

interface cle_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [cle_pkg::ST_W-1:0]   status;
  logic [cle_pkg::LEN_W-1:0]  line_length;
  logic [cle_pkg::CHAR_W-1:0] read_byte;

  modport source (output valid, output status, output line_length, output read_byte,
                  input ready);
  modport sink (input valid, input status, input line_length, input read_byte,
                output ready);
endinterface

[sv/console_line_editor_unit.sv]
// Console line editor: takes one event per cycle (character, end of input, or read of a
// stored byte) and answers in the cycle after the transfer from an output register; unused
// operation code 3 is taken and gives no answer. The line bytes sit in a small RAM with
// one write and one registered read port, so a read sees every byte written by any earlier
// event; the length and the line-open flag are registers. The request side stays ready
// while the output register is empty or being drained, so the sustained rate is one event
// per cycle. LINE_CAPACITY (1 to 255) sets the RAM depth; bytes past it are dropped.
module console_line_editor_unit #(
  parameter int LINE_CAPACITY = 128
) (
  input  logic          clk,
  input  logic          rst,
  cle_req_if.sink       req,
  cle_rsp_if.source     rsp
);

  localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

  logic                       accept;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [cle_pkg::CHAR_W-1:0] wr_data;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [cle_pkg::CHAR_W-1:0] rd_data;
  cle_pkg::rsp_t              edit_rsp;

  logic                       out_valid;
  cle_pkg::status_e           out_status;
  logic [cle_pkg::LEN_W-1:0]  out_length;
  logic                       out_hit;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  cle_edit #(
    .LINE_CAPACITY(LINE_CAPACITY),
    .AW           (AW)
  ) u_edit (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (req.operation),
    .char_code (req.char_code),
    .read_index(req.read_index),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rsp       (edit_rsp)
  );

  cle_ram #(
    .WIDTH(cle_pkg::CHAR_W),
    .DEPTH(LINE_CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= edit_rsp.valid;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= edit_rsp.status;
      out_length <= edit_rsp.length;
      out_hit    <= edit_rsp.hit;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.line_length = out_length;
  assign rsp.read_byte   = out_hit ? rd_data : '0;

endmodule

[sv/cle_ram.sv]
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/cle_edit.sv]
module cle_edit #(
  parameter int LINE_CAPACITY = 128,
  parameter int AW            = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [cle_pkg::OP_W-1:0]   operation,
  input  logic [cle_pkg::CHAR_W-1:0] char_code,
  input  logic [cle_pkg::IDX_W-1:0]  read_index,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [cle_pkg::CHAR_W-1:0] wr_data,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr,
  output cle_pkg::rsp_t              rsp
);

  localparam int LW = cle_pkg::LEN_W;
  localparam logic [LW-1:0] CAP = LW'(LINE_CAPACITY);

  logic [LW-1:0] length;
  logic [LW-1:0] length_next;
  logic          in_progress;
  logic          in_progress_next;
  logic [LW-1:0] base;
  logic          wr_req;
  logic          rd_req;

  always_comb begin
    base             = in_progress ? length : '0;
    length_next      = length;
    in_progress_next = in_progress;
    wr_req           = 1'b0;
    rd_req           = 1'b0;
    rsp.valid        = 1'b1;
    rsp.status       = cle_pkg::ST_PROGRESS;
    rsp.hit          = 1'b0;
    case (operation)
      cle_pkg::OP_CHAR: begin
        in_progress_next = 1'b1;
        length_next      = base;
        if (char_code == cle_pkg::CH_LF || char_code == cle_pkg::CH_CR) begin
          in_progress_next = 1'b0;
          rsp.status       = cle_pkg::ST_COMPLETE;
        end else if (char_code == cle_pkg::CH_BS || char_code == cle_pkg::CH_DEL) begin
          if (base != '0) begin
            length_next = base - LW'(1);
          end
        end else if (base < CAP) begin
          wr_req      = 1'b1;
          length_next = base + LW'(1);
        end
      end
      cle_pkg::OP_END: begin
        length_next      = base;
        in_progress_next = 1'b0;
        rsp.status       = (base != '0) ? cle_pkg::ST_COMPLETE : cle_pkg::ST_EOF;
      end
      cle_pkg::OP_READ: begin
        rd_req     = 1'b1;
        rsp.status = cle_pkg::ST_READ;
        rsp.hit    = (read_index < length);
      end
      default: begin
        rsp.valid = 1'b0;
      end
    endcase
    rsp.length = length_next;
  end

  assign wr_en   = accept && wr_req;
  assign wr_addr = base[AW-1:0];
  assign wr_data = char_code;
  assign rd_en   = accept && rd_req;
  assign rd_addr = read_index[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      length      <= '0;
      in_progress <= 1'b0;
    end else if (accept) begin
      length      <= length_next;
      in_progress <= in_progress_next;
    end
  end

endmodule

[sv/cle_checker.sv]
module cle_checker #(
  parameter int LINE_CAPACITY = 128
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic [cle_pkg::OP_W-1:0]   req_operation,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [cle_pkg::ST_W-1:0]   rsp_status,
  input logic [cle_pkg::LEN_W-1:0]  rsp_line_length,
  input logic [cle_pkg::CHAR_W-1:0] rsp_read_byte
);

  localparam int LW = cle_pkg::LEN_W;
  localparam logic [LW-1:0] CAP = LW'(LINE_CAPACITY);

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_length))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_line_length <= CAP)
    else $error("line length above capacity");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != cle_pkg::ST_READ |-> rsp_read_byte == '0)
    else $error("nonzero byte on an edit result");

  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_operation == cle_pkg::OP_UNUSED |=> !rsp_valid)
    else $error("result produced for unused operation");

  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_operation != cle_pkg::OP_UNUSED |=> rsp_valid)
    else $error("result missing after transfer");

endmodule

bind console_line_editor_unit cle_checker #(
  .LINE_CAPACITY(LINE_CAPACITY)
) u_cle_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_operation  (req.operation),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_line_length(rsp.line_length),
  .rsp_read_byte  (rsp.read_byte)
);

[test/tb_console_line_editor_unit.sv]
module tb_console_line_editor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_CAP = 128;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int EVENT_TARGET = 2000;

  typedef logic [cle_pkg::OP_W-1:0]   op_t;
  typedef logic [cle_pkg::CHAR_W-1:0] char_t;
  typedef logic [cle_pkg::IDX_W-1:0]  idx_t;

  typedef struct {
    cle_pkg::status_e            status;
    logic [cle_pkg::LEN_W-1:0]   length;
    logic [cle_pkg::CHAR_W-1:0]  data;
  } reply_t;

  class line_tracker;
    logic [cle_pkg::CHAR_W-1:0] line_bytes[LINE_CAP];
    int unsigned held;
    bit open;
    reply_t pending_replies[$];
    int mismatches;
    int replies_seen;
    int lines_done;
    int eof_seen;
    int dropped;

    function new();
      held = 0;
      open = 1'b0;
      mismatches = 0;
      replies_seen = 0;
      lines_done = 0;
      eof_seen = 0;
      dropped = 0;
      foreach (line_bytes[i]) line_bytes[i] = '0;
    endfunction

    function void take_event(logic [cle_pkg::OP_W-1:0] op, logic [cle_pkg::CHAR_W-1:0] ch,
                             logic [cle_pkg::IDX_W-1:0] idx);
      reply_t r;
      r.data = '0;
      case (op)
        cle_pkg::OP_CHAR: begin
          if (!open) begin
            open = 1'b1;
            held = 0;
          end
          if (ch == cle_pkg::CH_LF || ch == cle_pkg::CH_CR) begin
            open = 1'b0;
            r.status = cle_pkg::ST_COMPLETE;
            lines_done++;
          end else if (ch == cle_pkg::CH_BS || ch == cle_pkg::CH_DEL) begin
            if (held > 0) held--;
            r.status = cle_pkg::ST_PROGRESS;
          end else begin
            if (held < LINE_CAP) begin
              line_bytes[held] = ch;
              held++;
            end else begin
              dropped++;
            end
            r.status = cle_pkg::ST_PROGRESS;
          end
        end
        cle_pkg::OP_END: begin
          if (!open) held = 0;
          open = 1'b0;
          if (held > 0) begin
            r.status = cle_pkg::ST_COMPLETE;
            lines_done++;
          end else begin
            r.status = cle_pkg::ST_EOF;
            eof_seen++;
          end
        end
        cle_pkg::OP_READ: begin
          if (idx < held) r.data = line_bytes[idx];
          r.status = cle_pkg::ST_READ;
        end
        default: return;
      endcase
      r.length = held[cle_pkg::LEN_W-1:0];
      pending_replies.push_back(r);
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: reply %0d %s mismatch: got %0h, want %0h",
                 $time, replies_seen, what, got, want);
    endtask

    task check_reply(logic [cle_pkg::ST_W-1:0] st, logic [cle_pkg::LEN_W-1:0] len,
                     logic [cle_pkg::CHAR_W-1:0] b);
      reply_t e;
      replies_seen++;
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected", {6'd0, st}, 8'd0);
        return;
      end
      e = pending_replies.pop_front();
      if (st !== e.status) report_mismatch("status", {6'd0, st}, {6'd0, e.status});
      if (len !== e.length) report_mismatch("line_length", len, e.length);
      if (b !== e.data) report_mismatch("read_byte", b, e.data);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  int unsigned cycles = 0;
  bit quiet = 1'b0;
  bit hold_off_req = 1'b0;
  int events_sent = 0;
  int reads_sent = 0;

  cle_req_if req_bus();
  cle_rsp_if rsp_bus();

  console_line_editor_unit #(.LINE_CAPACITY(LINE_CAP)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  line_tracker tracker = new();

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("console_line_editor_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready)
      tracker.check_reply(rsp_bus.status, rsp_bus.line_length, rsp_bus.read_byte);
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin : sink_side
    int stall;
    rsp_bus.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        rsp_bus.ready <= 1'b1;
      end else begin
        stall = quiet ? 0 : idle_len();
        if (stall > 0) begin
          rsp_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_event(logic [cle_pkg::OP_W-1:0] op, logic [cle_pkg::CHAR_W-1:0] ch,
                            logic [cle_pkg::IDX_W-1:0] idx);
    int gap;
    req_bus.valid <= 1'b1;
    req_bus.operation <= op;
    req_bus.char_code <= ch;
    req_bus.read_index <= idx;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    tracker.take_event(op, ch, idx);
    if (op != cle_pkg::OP_UNUSED) events_sent++;
    if (op == cle_pkg::OP_READ) reads_sent++;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    if (req_bus.valid) req_bus.valid <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic random_line();
    int n;
    int r;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(125, 140) : $urandom_range(0, 20);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8)
        send_event(cle_pkg::OP_CHAR, $urandom_range(0, 1) ? cle_pkg::CH_BS : cle_pkg::CH_DEL,
                   idx_t'($urandom_range(0, 255)));
      else if (r < 18)
        send_event(cle_pkg::OP_READ, char_t'($urandom_range(0, 255)),
                   idx_t'($urandom_range(0, n + 2)));
      else
        send_event(cle_pkg::OP_CHAR, char_t'($urandom_range(32, 126)),
                   idx_t'($urandom_range(0, 255)));
    end
    r = $urandom_range(0, 9);
    if (r < 4) begin
      send_event(cle_pkg::OP_CHAR, cle_pkg::CH_CR, '0);
    end else if (r < 7) begin
      send_event(cle_pkg::OP_CHAR, cle_pkg::CH_LF, '0);
    end else begin
      send_event(cle_pkg::OP_END, char_t'($urandom_range(0, 255)),
                 idx_t'($urandom_range(0, 255)));
      if (r == 9) send_event(cle_pkg::OP_END, '0, '0);
    end
    repeat ($urandom_range(0, 3))
      send_event(cle_pkg::OP_READ, '0, idx_t'($urandom_range(0, n + 1)));
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 6))
      send_event(op_t'($urandom_range(0, 3)), char_t'($urandom_range(0, 255)),
                 idx_t'($urandom_range(0, 255)));
  endtask

  initial begin : source_side
    bit held_off;
    bit paused;
    held_off = 1'b0;
    paused = 1'b0;
    rst <= 1'b1;
    req_bus.valid <= 1'b0;
    req_bus.operation <= cle_pkg::OP_CHAR;
    req_bus.char_code <= '0;
    req_bus.read_index <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_event(cle_pkg::OP_END, '0, '0);
    send_event(cle_pkg::OP_END, '1, '1);
    send_event(cle_pkg::OP_CHAR, cle_pkg::CH_BS, '0);
    send_event(cle_pkg::OP_CHAR, cle_pkg::CH_DEL, '0);
    send_event(cle_pkg::OP_CHAR, 8'h00, '0);
    send_event(cle_pkg::OP_CHAR, 8'hFF, '0);
    send_event(cle_pkg::OP_CHAR, 8'h41, '0);
    send_event(cle_pkg::OP_READ, '0, 8'd0);
    send_event(cle_pkg::OP_READ, '0, 8'd1);
    send_event(cle_pkg::OP_READ, '0, 8'd3);
    send_event(cle_pkg::OP_READ, '1, 8'd255);
    send_event(cle_pkg::OP_CHAR, cle_pkg::CH_DEL, '0);
    send_event(cle_pkg::OP_CHAR, cle_pkg::CH_BS, '0);
    send_event(cle_pkg::OP_CHAR, cle_pkg::CH_CR, '0);
    send_event(cle_pkg::OP_READ, '0, 8'd0);
    send_event(cle_pkg::OP_CHAR, 8'h78, '0);
    send_event(cle_pkg::OP_CHAR, cle_pkg::CH_LF, '0);
    send_event(cle_pkg::OP_END, '0, '0);
    send_event(cle_pkg::OP_CHAR, 8'h71, '0);
    send_event(cle_pkg::OP_END, '0, '0);
    send_event(cle_pkg::OP_UNUSED, '1, '1);
    send_event(cle_pkg::OP_READ, '0, 8'd0);

    while (events_sent < EVENT_TARGET) begin
      if ($urandom_range(0, 9) == 0) quiet = ~quiet;
      if (!held_off && events_sent > 500) begin
        held_off = 1'b1;
        quiet = 1'b1;
        hold_off_req = 1'b1;
      end
      if (!paused && events_sent > 1200) begin
        paused = 1'b1;
        wait_drained();
      end
      if ($urandom_range(0, 99) < 80) random_line();
      else noise_burst();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d events (%0d reads) with idle gaps on both sides; checked %0d replies.",
             events_sent, reads_sent, tracker.replies_seen);
    $display("Saw %0d completed lines, %0d end-of-input reports, %0d bytes dropped when full.",
             tracker.lines_done, tracker.eof_seen, tracker.dropped);
    if (tracker.mismatches == 0)
      $display("console_line_editor_unit verification clean");
    else
      $display("console_line_editor_unit verification failed");
    $finish;
  end

endmodule
